// ----- src/stl_pkg.sv -----
`default_nettype none

package stl_pkg;

   // Default widths of position and offset counters
   localparam int DEF_POS_BITS    = 16;
   localparam int DEF_OFFSET_BITS = 24;

   // Entries in the queue between classifier and record emitter
   localparam int QUEUE_DEPTH = 4;

   // Token kinds
   localparam logic [4:0] KIND_LBRACE  = 5'd0;
   localparam logic [4:0] KIND_RBRACE  = 5'd1;
   localparam logic [4:0] KIND_LPAREN  = 5'd2;
   localparam logic [4:0] KIND_RPAREN  = 5'd3;
   localparam logic [4:0] KIND_SEMI    = 5'd4;
   localparam logic [4:0] KIND_PLUS    = 5'd5;
   localparam logic [4:0] KIND_MINUS   = 5'd6;
   localparam logic [4:0] KIND_STAR    = 5'd7;
   localparam logic [4:0] KIND_SLASH   = 5'd8;
   localparam logic [4:0] KIND_PERCENT = 5'd9;
   localparam logic [4:0] KIND_AND     = 5'd10;
   localparam logic [4:0] KIND_OR      = 5'd11;
   localparam logic [4:0] KIND_GE      = 5'd12;
   localparam logic [4:0] KIND_GT      = 5'd13;
   localparam logic [4:0] KIND_LE      = 5'd14;
   localparam logic [4:0] KIND_LT      = 5'd15;
   localparam logic [4:0] KIND_EQ      = 5'd16;
   localparam logic [4:0] KIND_ASSIGN  = 5'd17;
   localparam logic [4:0] KIND_NE      = 5'd18;
   localparam logic [4:0] KIND_NOT     = 5'd19;
   localparam logic [4:0] KIND_NAME    = 5'd20;
   localparam logic [4:0] KIND_INT     = 5'd21;
   localparam logic [4:0] KIND_KW_READ = 5'd22;
   localparam logic [4:0] KIND_ERR     = 5'd27;
   localparam logic [4:0] KIND_NONE    = 5'd31;

   localparam int NUM_KEYWORDS = 5;

   // Keyword text, first byte in the low bits, zero padded
   localparam logic [39:0] KW_TEXT [NUM_KEYWORDS] = '{
      40'h00_64_61_65_72,   // read
      40'h74_6E_69_72_70,   // print
      40'h00_6C_6C_61_63,   // call
      40'h65_6C_69_68_77,   // while
      40'h00_00_00_66_69    // if
   };
   localparam logic [7:0] KW_LEN [NUM_KEYWORDS] = '{8'd4, 8'd5, 8'd4, 8'd5, 8'd2};

   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_BAR   = 8'h7C;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;

   localparam logic [7:0] LEN_MAX = 8'd255;

   typedef struct packed {
      logic full;
      logic empty;
   } stl_q_stat_type;

   function automatic int rec_width(input int pos_bits, input int offset_bits);
      return 13 + 4 * pos_bits + offset_bits;
   endfunction

   function automatic int ent_width(input int pos_bits, input int offset_bits);
      return 1 + 2 * rec_width(pos_bits, offset_bits);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return b inside {[8'h61:8'h7A], [8'h41:8'h5A]};
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic logic [4:0] single_kind(input logic [7:0] b);
      logic [4:0] k;
      case (b)
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h3B:   k = KIND_SEMI;
         8'h2B:   k = KIND_PLUS;
         8'h2D:   k = KIND_MINUS;
         8'h2A:   k = KIND_STAR;
         8'h2F:   k = KIND_SLASH;
         8'h25:   k = KIND_PERCENT;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] cmp_kind(input logic [7:0] b);
      logic [4:0] k;
      case (b)
         8'h3E:   k = KIND_GT;
         8'h3C:   k = KIND_LT;
         8'h3D:   k = KIND_ASSIGN;
         8'h21:   k = KIND_NOT;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

   // Name or keyword: length and padded prefix must both match
   function automatic logic [4:0] word_kind(input logic [7:0] len, input logic [39:0] pfx);
      logic [4:0] k;
      k = KIND_NAME;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         if (len == KW_LEN[i] && pfx == KW_TEXT[i]) begin
            k = KIND_KW_READ + 5'(i);
         end
      end
      return k;
   endfunction

endpackage

`default_nettype wire

// ----- src/stl_channels.sv -----
`default_nettype none

interface stl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_text;

   modport source (output valid, output char_byte, output end_of_text, input ready);
   modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface stl_rsp_if #(
   parameter int POS_BITS    = stl_pkg::DEF_POS_BITS,
   parameter int OFFSET_BITS = stl_pkg::DEF_OFFSET_BITS
);
   logic                   valid;
   logic                   ready;
   logic [4:0]             token_kind;
   logic [POS_BITS-1:0]    start_row;
   logic [POS_BITS-1:0]    start_col;
   logic [POS_BITS-1:0]    end_row;
   logic [POS_BITS-1:0]    end_col;
   logic [OFFSET_BITS-1:0] start_offset;
   logic [7:0]             text_length;
   logic                   run_last;

   modport source (output valid, output token_kind, output start_row, output start_col,
                   output end_row, output end_col, output start_offset,
                   output text_length, output run_last, input ready);
   modport sink   (input valid, input token_kind, input start_row, input start_col,
                   input end_row, input end_col, input start_offset,
                   input text_length, input run_last, output ready);
endinterface

`default_nettype wire

// ----- src/stl_front.sv -----
`default_nettype none

module stl_front #(
   parameter int POS_BITS    = stl_pkg::DEF_POS_BITS,
   parameter int OFFSET_BITS = stl_pkg::DEF_OFFSET_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             char_byte,
   input  logic                   end_of_text,
   input  stl_pkg::stl_q_stat_type q_stat,
   output logic                   push,
   output logic [stl_pkg::ent_width(POS_BITS, OFFSET_BITS)-1:0] push_entry
);
   import stl_pkg::*;

   typedef struct packed {
      logic [4:0]             kind;
      logic [POS_BITS-1:0]    start_row;
      logic [POS_BITS-1:0]    start_col;
      logic [POS_BITS-1:0]    end_row;
      logic [POS_BITS-1:0]    end_col;
      logic [OFFSET_BITS-1:0] start_offset;
      logic [7:0]             text_length;
   } rec_type;

   logic [POS_BITS-1:0]    cur_row_ff, cur_row_in, cur_col_ff, cur_col_in;
   logic [OFFSET_BITS-1:0] cur_off_ff, cur_off_in;
   logic [4:0]             pend_kind_ff, pend_kind_in;
   logic [POS_BITS-1:0]    pend_row_ff, pend_row_in, pend_col_ff, pend_col_in;
   logic [OFFSET_BITS-1:0] pend_off_ff, pend_off_in;
   logic [7:0]             pend_len_ff, pend_len_in;
   logic [39:0]            prefix_ff, prefix_in;

   logic [POS_BITS-1:0]    row_nx, col_nx;
   logic [OFFSET_BITS-1:0] off_nx;
   rec_type                rec_a, rec_b, rec_c, slot0, slot1;
   logic                   a_vld, b_vld, c_vld, taken, accept;

   function automatic rec_type flush_rec(
      input logic [4:0]             kind,
      input logic [POS_BITS-1:0]    prow,
      input logic [POS_BITS-1:0]    pcol,
      input logic [OFFSET_BITS-1:0] poff,
      input logic [7:0]             plen,
      input logic [39:0]            pfx,
      input logic [POS_BITS-1:0]    er,
      input logic [POS_BITS-1:0]    ec
   );
      rec_type rec;
      rec = '{kind, prow, pcol, prow, pcol, poff, 8'd1};
      if (kind == KIND_NAME) begin
         rec = '{word_kind(plen, pfx), prow, pcol, er, ec, poff, plen};
      end else if (kind == KIND_INT) begin
         rec = '{KIND_INT, prow, pcol, er, ec, poff, plen};
      end else if (kind == KIND_AND || kind == KIND_OR) begin
         // cut-off pair
         rec.kind = KIND_ERR;
      end
      return rec;
   endfunction

   assign in_ready = !q_stat.full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      rec_a        = '0;
      rec_b        = '0;
      rec_c        = '0;
      a_vld        = 1'b0;
      b_vld        = 1'b0;
      c_vld        = 1'b0;
      taken        = 1'b0;
      pend_kind_in = pend_kind_ff;
      pend_row_in  = pend_row_ff;
      pend_col_in  = pend_col_ff;
      pend_off_in  = pend_off_ff;
      pend_len_in  = pend_len_ff;
      prefix_in    = prefix_ff;

      // Settle the pending token against this byte
      case (pend_kind_ff)
         KIND_AND, KIND_OR: begin
            rec_a = '{pend_kind_ff, pend_row_ff, pend_col_ff, cur_row_ff, cur_col_ff,
                      pend_off_ff, 8'd2};
            a_vld = 1'b1;
            taken = 1'b1;
            pend_kind_in = KIND_NONE;
         end
         KIND_GT, KIND_LT, KIND_ASSIGN, KIND_NOT: begin
            if (char_byte == CHAR_EQUAL) begin
               rec_a = '{pend_kind_ff - 5'd1, pend_row_ff, pend_col_ff, cur_row_ff,
                         cur_col_ff, pend_off_ff, 8'd2};
               taken = 1'b1;
            end else begin
               rec_a = flush_rec(pend_kind_ff, pend_row_ff, pend_col_ff, pend_off_ff,
                                 pend_len_ff, prefix_ff, cur_row_ff, cur_col_ff);
            end
            a_vld = 1'b1;
            pend_kind_in = KIND_NONE;
         end
         KIND_NAME, KIND_INT: begin
            if (is_digit(char_byte) || (pend_kind_ff == KIND_NAME && is_alpha(char_byte)))
            begin
               taken = 1'b1;
               for (int i = 0; i < 5; i++) begin
                  if (pend_len_ff == 8'(i)) begin
                     prefix_in[8*i +: 8] = char_byte;
                  end
               end
               if (pend_len_ff != LEN_MAX) begin
                  pend_len_in = pend_len_ff + 8'd1;
               end
            end else begin
               rec_a = flush_rec(pend_kind_ff, pend_row_ff, pend_col_ff, pend_off_ff,
                                 pend_len_ff, prefix_ff, cur_row_ff, cur_col_ff);
               a_vld = 1'b1;
               pend_kind_in = KIND_NONE;
            end
         end
         default: begin
         end
      endcase

      // Classify the byte when it did not extend the pending token
      if (!taken && !is_space(char_byte)) begin
         if (single_kind(char_byte) != KIND_NONE) begin
            rec_b = '{single_kind(char_byte), cur_row_ff, cur_col_ff, cur_row_ff,
                      cur_col_ff, cur_off_ff, 8'd1};
            b_vld = 1'b1;
         end else if (char_byte == CHAR_AMP || char_byte == CHAR_BAR ||
                      cmp_kind(char_byte) != KIND_NONE || is_alpha(char_byte) ||
                      is_digit(char_byte)) begin
            pend_row_in = cur_row_ff;
            pend_col_in = cur_col_ff;
            pend_off_in = cur_off_ff;
            pend_len_in = 8'd0;
            prefix_in   = '0;
            if (char_byte == CHAR_AMP) begin
               pend_kind_in = KIND_AND;
            end else if (char_byte == CHAR_BAR) begin
               pend_kind_in = KIND_OR;
            end else if (cmp_kind(char_byte) != KIND_NONE) begin
               pend_kind_in = cmp_kind(char_byte);
            end else begin
               pend_kind_in = is_alpha(char_byte) ? KIND_NAME : KIND_INT;
               pend_len_in  = 8'd1;
               prefix_in    = {32'd0, char_byte};
            end
         end else begin
            rec_b = '{KIND_ERR, cur_row_ff, cur_col_ff, cur_row_ff, cur_col_ff,
                      cur_off_ff, 8'd1};
            b_vld = 1'b1;
         end
      end

      off_nx = cur_off_ff + 1'b1;
      if (char_byte == CHAR_NL) begin
         row_nx = cur_row_ff + 1'b1;
         col_nx = '0;
      end else begin
         row_nx = cur_row_ff;
         col_nx = cur_col_ff + 1'b1;
      end

      // End of text: flush and restart the counters
      cur_row_in = row_nx;
      cur_col_in = col_nx;
      cur_off_in = off_nx;
      if (end_of_text) begin
         c_vld = pend_kind_in != KIND_NONE;
         rec_c = flush_rec(pend_kind_in, pend_row_in, pend_col_in, pend_off_in,
                           pend_len_in, prefix_in, row_nx, col_nx);
         pend_kind_in = KIND_NONE;
         cur_row_in   = '0;
         cur_col_in   = '0;
         cur_off_in   = '0;
      end
   end

   // Pack up to two records, in order, into one queue entry
   always_comb begin
      if (a_vld) begin
         slot0 = rec_a;
      end else if (b_vld) begin
         slot0 = rec_b;
      end else begin
         slot0 = rec_c;
      end
      slot1 = (a_vld && b_vld) ? rec_b : rec_c;
   end

   assign push       = accept && (a_vld || b_vld || c_vld);
   assign push_entry = {(a_vld && b_vld) || ((a_vld || b_vld) && c_vld), slot1, slot0};

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         cur_off_ff   <= '0;
         pend_kind_ff <= KIND_NONE;
      end else if (accept) begin
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         cur_off_ff   <= cur_off_in;
         pend_kind_ff <= pend_kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_row_ff <= pend_row_in;
         pend_col_ff <= pend_col_in;
         pend_off_ff <= pend_off_in;
         pend_len_ff <= pend_len_in;
         prefix_ff   <= prefix_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/stl_queue.sv -----
`default_nettype none

module stl_queue #(
   parameter int WIDTH = stl_pkg::ent_width(stl_pkg::DEF_POS_BITS, stl_pkg::DEF_OFFSET_BITS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       push_entry,
   input  logic                   pop,
   output logic [WIDTH-1:0]       head_entry,
   output stl_pkg::stl_q_stat_type q_stat
);
   import stl_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_stat.full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign q_stat.empty = count_ff == '0;
   assign head_entry   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- src/stl_back.sv -----
`default_nettype none

module stl_back #(
   parameter int POS_BITS    = stl_pkg::DEF_POS_BITS,
   parameter int OFFSET_BITS = stl_pkg::DEF_OFFSET_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  stl_pkg::stl_q_stat_type q_stat,
   input  logic [stl_pkg::ent_width(POS_BITS, OFFSET_BITS)-1:0] head_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [4:0]             rsp_token_kind,
   output logic [POS_BITS-1:0]    rsp_start_row,
   output logic [POS_BITS-1:0]    rsp_start_col,
   output logic [POS_BITS-1:0]    rsp_end_row,
   output logic [POS_BITS-1:0]    rsp_end_col,
   output logic [OFFSET_BITS-1:0] rsp_start_offset,
   output logic [7:0]             rsp_text_length,
   output logic                   rsp_run_last
);
   import stl_pkg::*;

   localparam int REC_W = rec_width(POS_BITS, OFFSET_BITS);

   typedef struct packed {
      logic [4:0]             kind;
      logic [POS_BITS-1:0]    start_row;
      logic [POS_BITS-1:0]    start_col;
      logic [POS_BITS-1:0]    end_row;
      logic [POS_BITS-1:0]    end_col;
      logic [OFFSET_BITS-1:0] start_offset;
      logic [7:0]             text_length;
   } rec_type;

   logic    out_vld_ff, out_vld_in, sel_ff, sel_in, last_ff, last_in;
   rec_type out_rec_ff, out_rec_in;
   logic    load, two;

   assign two  = head_entry[2*REC_W];
   assign load = !out_vld_ff || rsp_ready;
   assign pop  = load && !q_stat.empty && (sel_ff || !two);

   // Step through the one or two records of the head entry
   always_comb begin
      out_vld_in = out_vld_ff;
      out_rec_in = out_rec_ff;
      last_in    = last_ff;
      sel_in     = sel_ff;
      if (load) begin
         out_vld_in = !q_stat.empty;
         out_rec_in = sel_ff ? rec_type'(head_entry[REC_W +: REC_W])
                             : rec_type'(head_entry[0 +: REC_W]);
         last_in    = sel_ff || !two;
         sel_in     = !q_stat.empty && !sel_ff && two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         sel_ff     <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
         sel_ff     <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      out_rec_ff <= out_rec_in;
      last_ff    <= last_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_token_kind   = out_rec_ff.kind;
   assign rsp_start_row    = out_rec_ff.start_row;
   assign rsp_start_col    = out_rec_ff.start_col;
   assign rsp_end_row      = out_rec_ff.end_row;
   assign rsp_end_col      = out_rec_ff.end_col;
   assign rsp_start_offset = out_rec_ff.start_offset;
   assign rsp_text_length  = out_rec_ff.text_length;
   assign rsp_run_last     = last_ff;

endmodule

`default_nettype wire

// ----- src/source_text_lexer_core.sv -----
// Streaming lexer: one source byte per cycle on req_ch, token records on rsp_ch.
// The classifier takes a byte in every cycle while its four-entry queue has room;
// each byte turns into zero, one or two records, which the emitter hands out one
// per cycle from its output register while rsp_ch is ready. The first record of
// a byte is written to the queue and then to the output register. Tokens whose end
// needs lookahead (names, integers, comparison pairs) come out with the following byte
// or at end_of_text, which flushes the pending token and returns row, column and
// offset to zero for the next text.
`default_nettype none

module source_text_lexer_core #(
   parameter int POS_BITS    = stl_pkg::DEF_POS_BITS,
   parameter int OFFSET_BITS = stl_pkg::DEF_OFFSET_BITS
) (
   input logic       clock,
   input logic       reset,
   stl_req_if.sink   req_ch,
   stl_rsp_if.source rsp_ch
);
   import stl_pkg::*;

   localparam int ENT_W = ent_width(POS_BITS, OFFSET_BITS);

   stl_q_stat_type   q_stat;
   logic             push, pop;
   logic [ENT_W-1:0] push_entry, head_entry;

   stl_front #(.POS_BITS(POS_BITS), .OFFSET_BITS(OFFSET_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .char_byte   (req_ch.char_byte),
      .end_of_text (req_ch.end_of_text),
      .q_stat      (q_stat),
      .push        (push),
      .push_entry  (push_entry)
   );

   stl_queue #(.WIDTH(ENT_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_stat     (q_stat)
   );

   stl_back #(.POS_BITS(POS_BITS), .OFFSET_BITS(OFFSET_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_stat           (q_stat),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_token_kind   (rsp_ch.token_kind),
      .rsp_start_row    (rsp_ch.start_row),
      .rsp_start_col    (rsp_ch.start_col),
      .rsp_end_row      (rsp_ch.end_row),
      .rsp_end_col      (rsp_ch.end_col),
      .rsp_start_offset (rsp_ch.start_offset),
      .rsp_text_length  (rsp_ch.text_length),
      .rsp_run_last     (rsp_ch.run_last)
   );

endmodule

`default_nettype wire

// ----- src/stl_checker.sv -----
`default_nettype none

module stl_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] rsp_token_kind,
   input logic [7:0] rsp_text_length
);
   import stl_pkg::*;

   // A stalled record stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("record dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("record offered right after reset");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_kind <= KIND_ERR)
      else $error("token kind out of range");

   // Single-byte tokens and errors span one byte
   a_single_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind <= KIND_PERCENT || rsp_token_kind == KIND_ERR)
      |-> rsp_text_length == 8'd1)
      else $error("single-byte token with wrong length");

   a_pair_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == KIND_AND || rsp_token_kind == KIND_OR ||
                    rsp_token_kind == KIND_GE || rsp_token_kind == KIND_LE ||
                    rsp_token_kind == KIND_EQ || rsp_token_kind == KIND_NE)
      |-> rsp_text_length == 8'd2)
      else $error("two-byte operator with wrong length");

endmodule

bind source_text_lexer_core stl_checker u_stl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_token_kind  (rsp_ch.token_kind),
   .rsp_text_length (rsp_ch.text_length)
);

`default_nettype wire
